FILE: design/mtpq_pkg.sv
`timescale 1ns / 1ps
package mtpq_pkg;
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_QUEUED = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_NOMEM  = 3'd4;

  localparam int unsigned NODE_W = 12;
  localparam int unsigned KEYIN_W = 32;
  localparam int unsigned SIZE_W = 11;
endpackage

FILE: design/min_tracking_priority_queue.sv
`timescale 1ns / 1ps
// Unsorted-array priority queue with cached minimum. After reset the block
// clears every entry of the membership memory before taking a word. Push,
// refused ops and query finish with the output handshake; a remove also moves
// the last entry into the freed slot, and a remove of the minimum adds one
// comparison step per remaining entry (up to QUEUE_DEPTH - 1) for the rescan.
module min_tracking_priority_queue import mtpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024,
  parameter int unsigned NODE_COUNT  = 4096,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SIZE_W-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [NODE_W-1:0]   node_id_i,
  input  logic [KEYIN_W-1:0]  key_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [NODE_W-1:0]   min_node_o,
  output logic [KEYIN_W-1:0]  min_key_o,
  output logic [SIZE_W-1:0]   queue_size_o
);
  logic [SIZE_W-1:0] max_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_size_q <= SIZE_W'(1024);
    else if (cfg_valid_i) max_size_q <= cfg_data_i;
  end
  assign cfg_ready_o = 1'b1;

  mtpq_seq #(.QUEUE_DEPTH(QUEUE_DEPTH), .NODE_COUNT(NODE_COUNT), .KEY_BITS(KEY_BITS))
  u_seq (
    .clk_i, .rst_ni, .max_size_i(max_size_q), .in_valid_i, .in_ready_o,
    .opcode_i, .node_id_i, .key_value_i, .out_valid_o, .out_ready_i,
    .status_o, .min_node_o, .min_key_o, .queue_size_o
  );
endmodule

FILE: design/mtpq_ram.sv
`timescale 1ns / 1ps
module mtpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: design/mtpq_seq.sv
`timescale 1ns / 1ps
module mtpq_seq import mtpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024,
  parameter int unsigned NODE_COUNT  = 4096,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SIZE_W-1:0]   max_size_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [NODE_W-1:0]   node_id_i,
  input  logic [KEYIN_W-1:0]  key_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [NODE_W-1:0]   min_node_o,
  output logic [KEYIN_W-1:0]  min_key_o,
  output logic [SIZE_W-1:0]   queue_size_o
);
  localparam int unsigned SW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int unsigned IDW = (NW > NODE_W) ? NW : NODE_W;
  localparam logic [KEY_BITS-1:0] KEY_ONES = '1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_RD1    = 4'd2;
  localparam logic [3:0] S_DEC    = 4'd3;
  localparam logic [3:0] S_RMRD   = 4'd4;
  localparam logic [3:0] S_RMWR   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_MINRD  = 4'd8;
  localparam logic [3:0] S_MINW   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [SW-1:0] min_slot_q, min_slot_d;
  logic [KEY_BITS-1:0] min_cost_q, min_cost_d;
  logic [NW-1:0] clr_q, clr_d;
  logic [1:0] op_q, op_d;
  logic [IDW-1:0] id_q, id_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [SW-1:0] pos_q, pos_d, scan_q, scan_d;
  logic [2:0] st_q, st_d;
  logic [NODE_W-1:0] mnode_q, mnode_d;
  logic ov_q, ov_d;

  // memories
  logic nq_we, nq_wd, nq_rd;  logic [NW-1:0] nq_wa, nq_ra;
  logic ns_we;  logic [NW-1:0] ns_wa, ns_ra;  logic [SW-1:0] ns_wd, ns_rd;
  logic sn_we;  logic [SW-1:0] sn_wa, sn_ra;  logic [NW-1:0] sn_wd, sn_rd;
  logic sk_we;  logic [SW-1:0] sk_wa, sk_ra;  logic [KEY_BITS-1:0] sk_wd, sk_rd;

  mtpq_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_queued (.clk_i, .we_i(nq_we),
    .waddr_i(nq_wa), .wdata_i(nq_wd), .raddr_i(nq_ra), .rdata_o(nq_rd));
  mtpq_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_nslot (.clk_i, .we_i(ns_we),
    .waddr_i(ns_wa), .wdata_i(ns_wd), .raddr_i(ns_ra), .rdata_o(ns_rd));
  mtpq_ram #(.WIDTH(NW), .DEPTH(QUEUE_DEPTH)) u_snode (.clk_i, .we_i(sn_we),
    .waddr_i(sn_wa), .wdata_i(sn_wd), .raddr_i(sn_ra), .rdata_o(sn_rd));
  mtpq_ram #(.WIDTH(KEY_BITS), .DEPTH(QUEUE_DEPTH)) u_skey (.clk_i, .we_i(sk_we),
    .waddr_i(sk_wa), .wdata_i(sk_wd), .raddr_i(sk_ra), .rdata_o(sk_rd));

  logic [CW-1:0] limit;
  logic in_range;
  logic [SW-1:0] last;
  logic [LW-1:0] max_ext;

  always_comb begin
    max_ext = LW'(max_size_i);
    limit = (max_ext < LW'(QUEUE_DEPTH)) ? CW'(max_ext) : CW'(QUEUE_DEPTH);
    in_range = (IDW + 1)'(id_q) < (IDW + 1)'(NODE_COUNT);
    last = SW'(fill_q - 1'b1);
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; min_slot_d = min_slot_q;
    min_cost_d = min_cost_q; clr_d = clr_q; op_d = op_q; id_d = id_q;
    key_d = key_q; pos_d = pos_q; scan_d = scan_q; st_d = st_q;
    mnode_d = mnode_q; ov_d = ov_q;
    nq_we = 1'b0; nq_wa = NW'(id_q); nq_wd = 1'b0; nq_ra = NW'(id_q);
    ns_we = 1'b0; ns_wa = NW'(id_q); ns_wd = pos_q; ns_ra = NW'(id_q);
    sn_we = 1'b0; sn_wa = pos_q; sn_wd = NW'(id_q); sn_ra = last;
    sk_we = 1'b0; sk_wa = pos_q; sk_wd = key_q; sk_ra = last;
    unique case (state_q)
      S_CLR: begin
        nq_we = 1'b1; nq_wa = clr_q; nq_wd = 1'b0;
        clr_d = clr_q + 1'b1;
        if (clr_q == NW'(NODE_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = opcode_i; id_d = IDW'(node_id_i);
          key_d = KEY_BITS'(key_value_i);
          state_d = S_RD1;
        end
      end
      S_RD1: state_d = S_DEC;  // queued bit, node slot, last entry in flight
      S_DEC: begin
        st_d = ST_OK;
        state_d = S_MINRD;
        if (op_q == OP_PUSH) begin
          if (fill_q >= limit) st_d = ST_FULL;
          else if (!in_range || nq_rd) st_d = ST_QUEUED;
          else begin
            pos_d = SW'(fill_q);
            nq_we = 1'b1; nq_wd = 1'b1;
            ns_we = 1'b1; ns_wd = SW'(fill_q);
            sn_we = 1'b1; sn_wa = SW'(fill_q);
            sk_we = 1'b1; sk_wa = SW'(fill_q);
            if (key_q < min_cost_q) begin
              min_cost_d = key_q; min_slot_d = SW'(fill_q);
            end
            fill_d = fill_q + 1'b1;
          end
        end else if (op_q == OP_REMOVE) begin
          if (fill_q == '0) st_d = ST_EMPTY;
          else if (!in_range || !nq_rd) st_d = ST_NOMEM;
          else begin
            pos_d = (ns_rd > last) ? last : ns_rd;
            state_d = S_RMWR;
          end
        end
      end
      S_RMWR: begin
        // move last entry into freed slot
        sn_we = 1'b1; sn_wd = sn_rd; sk_we = 1'b1; sk_wd = sk_rd;
        ns_we = 1'b1; ns_wa = sn_rd;
        state_d = S_RMRD;
      end
      S_RMRD: begin
        nq_we = 1'b1; nq_wd = 1'b0;
        ns_we = 1'b1; ns_wd = '0;
        fill_d = fill_q - 1'b1;
        if (pos_q == min_slot_q) begin
          min_slot_d = '0; min_cost_d = KEY_ONES; scan_d = '0;
          sk_ra = '0;
          state_d = (fill_q == CW'(1)) ? S_MINRD : S_SCAN;
        end else begin
          if (min_slot_q == last) min_slot_d = pos_q;
          state_d = S_MINRD;
        end
      end
      S_SCAN: begin
        // sk_rd holds key of slot scan_q; strict less keeps lowest slot
        if (scan_q == '0 || sk_rd < min_cost_q) begin
          min_cost_d = sk_rd; min_slot_d = scan_q;
        end
        if (CW'(scan_q) + 1'b1 >= fill_q) state_d = S_MINRD;
        else begin
          scan_d = scan_q + 1'b1; sk_ra = scan_q + 1'b1;
        end
      end
      S_MINRD: begin
        sn_ra = min_slot_q; state_d = S_MINW;
      end
      S_MINW: begin
        mnode_d = (fill_q == '0) ? '0 : NODE_W'(sn_rd);
        ov_d = 1'b1; state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin ov_d = 1'b0; state_d = S_IDLE; end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_IDLE || state_q == S_RD1) begin
      sn_ra = last; sk_ra = last;
    end
    if (state_q == S_SCAN && state_d != S_SCAN) sk_ra = scan_q;
    if (state_q == S_RMRD && state_d == S_SCAN) sk_ra = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; fill_q <= '0; min_slot_q <= '0; min_cost_q <= KEY_ONES;
      clr_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; min_slot_q <= min_slot_d;
      min_cost_q <= min_cost_d; clr_q <= clr_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; id_q <= id_d; key_q <= key_d; pos_q <= pos_d; scan_q <= scan_d;
    st_q <= st_d; mnode_q <= mnode_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = ov_q;
  assign status_o     = st_q;
  assign min_node_o   = mnode_q;
  assign min_key_o    = (fill_q == '0) ? '1 : KEYIN_W'(min_cost_q);
  assign queue_size_o = SIZE_W'(fill_q);

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(fill_q) <= CW'(QUEUE_DEPTH)) else $error("fill above depth");
  a_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && fill_q != '0) |-> CW'(min_slot_q) < fill_q)
    else $error("min slot outside fill");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && fill_q == '0) |-> min_cost_q == KEY_ONES)
    else $error("empty queue keeps a minimum");
endmodule
